@@ hdl/scdt_pkg.sv @@
// ----------------------------------------------------------------------------
// scdt_pkg
// Shared constants, types and helpers for the serial command trigger timer.
// ----------------------------------------------------------------------------
package scdt_pkg;

  localparam int DIGITS_PER_VALUE = 3;
  localparam int PERIOD_WIDTH     = 10;
  localparam int TOTAL_DIGITS     = 2 * DIGITS_PER_VALUE;
  // position runs from 0 up to one past the last digit
  localparam int POS_W            = $clog2(TOTAL_DIGITS + 2);
  localparam int DIGIT_IDX_W      = $clog2(TOTAL_DIGITS);
  localparam int DIGIT_W          = 4;
  localparam int VALUE_WIDTH      = 10;
  localparam int RADIX            = 10;
  localparam int OUT_TDATA_W      = 32;

  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef logic [PERIOD_WIDTH-1:0] period_t;
  typedef logic [TOTAL_DIGITS-1:0][DIGIT_W-1:0] digit_store_t;

  typedef struct packed {
    logic start;
    logic halt;
    logic done;
    logic error;
  } scdt_ctl_t;

  // decimal digits, most significant first, wrapping in the period width
  function automatic period_t gather(input digit_store_t store, input int base);
    period_t                   v;
    logic [PERIOD_WIDTH+3:0]   acc;
    v = '0;
    for (int k = 0; k < DIGITS_PER_VALUE; k++) begin
      acc = {4'b0000, v} * (PERIOD_WIDTH + 4)'(RADIX)
          + (PERIOD_WIDTH + 4)'(store[base + k]);
      v = acc[PERIOD_WIDTH-1:0];
    end
    return v;
  endfunction

endpackage

@@ hdl/scdt_parser.sv @@
// ----------------------------------------------------------------------------
// scdt_parser
// Command framing, digit capture and period latching.
// ----------------------------------------------------------------------------
module scdt_parser
  import scdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       kind,
  input  logic [7:0] byte_value,
  output scdt_ctl_t  ctl,
  output period_t    first_period_next,
  output period_t    second_period_next
);

  logic [POS_W-1:0] position;
  logic [POS_W-1:0] position_next;
  logic             frame_valid;
  logic             frame_valid_next;
  digit_store_t     digit_store;
  digit_store_t     digit_store_next;
  period_t          first_period;
  period_t          second_period;
  logic             is_digit;
  logic [7:0]       digit_raw;
  logic [POS_W-1:0] slot;
  period_t          gath_first;
  period_t          gath_second;

  assign is_digit  = (byte_value >= CHAR_0) && (byte_value <= CHAR_9);
  assign digit_raw = byte_value - CHAR_0;
  assign slot      = position - POS_W'(1);
  assign gath_first  = gather(digit_store, 0);
  assign gath_second = gather(digit_store, DIGITS_PER_VALUE);

  always_comb begin
    position_next      = position;
    frame_valid_next   = frame_valid;
    digit_store_next   = digit_store;
    first_period_next  = first_period;
    second_period_next = second_period;
    ctl                = '0;
    if (kind == KIND_BYTE) begin
      if (position == '0) begin
        if (byte_value == CHAR_S) begin
          frame_valid_next = 1'b1;
          position_next    = POS_W'(1);
        end else begin
          frame_valid_next = 1'b0;
          ctl.halt         = 1'b1;
          ctl.error        = 1'b1;
        end
      end else if ((position <= POS_W'(TOTAL_DIGITS)) && frame_valid) begin
        if (is_digit) begin
          digit_store_next[slot[DIGIT_IDX_W-1:0]] = digit_raw[DIGIT_W-1:0];
          position_next = position + POS_W'(1);
        end else begin
          position_next    = '0;
          frame_valid_next = 1'b0;
          ctl.halt         = 1'b1;
          ctl.error        = 1'b1;
        end
      end else begin
        // terminator byte
        position_next = '0;
        if (frame_valid) begin
          frame_valid_next   = 1'b0;
          first_period_next  = gath_first;
          second_period_next = gath_second;
          ctl.done           = 1'b1;
          if ((gath_first == '0) || (gath_second == '0)) begin
            ctl.halt = 1'b1;
          end else begin
            ctl.start = 1'b1;
          end
        end else begin
          ctl.halt  = 1'b1;
          ctl.error = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      frame_valid   <= 1'b0;
      digit_store   <= '0;
      first_period  <= '0;
      second_period <= '0;
    end else if (step) begin
      position      <= position_next;
      frame_valid   <= frame_valid_next;
      digit_store   <= digit_store_next;
      first_period  <= first_period_next;
      second_period <= second_period_next;
    end
  end

endmodule

@@ hdl/scdt_timer.sv @@
// ----------------------------------------------------------------------------
// scdt_timer
// Two tick counters driving the toggle outputs.
// ----------------------------------------------------------------------------
module scdt_timer
  import scdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  logic      tick,
  input  scdt_ctl_t ctl,
  input  period_t   first_period,
  input  period_t   second_period,
  output logic      running_next,
  output logic      first_out_next,
  output logic      second_out_next
);

  logic    running;
  logic    first_out;
  logic    second_out;
  period_t first_count;
  period_t first_count_next;
  period_t second_count;
  period_t second_count_next;
  period_t first_adv;
  period_t second_adv;

  assign first_adv  = (first_count == first_period)   ? '0 : first_count + PERIOD_WIDTH'(1);
  assign second_adv = (second_count == second_period) ? '0 : second_count + PERIOD_WIDTH'(1);

  always_comb begin
    running_next      = running;
    first_out_next    = first_out;
    second_out_next   = second_out;
    first_count_next  = first_count;
    second_count_next = second_count;
    if (ctl.halt) begin
      running_next    = 1'b0;
      first_out_next  = 1'b0;
      second_out_next = 1'b0;
    end else if (ctl.start) begin
      // preload so the first tick advances onto the period and toggles
      running_next      = 1'b1;
      first_out_next    = 1'b0;
      second_out_next   = 1'b0;
      first_count_next  = first_period - PERIOD_WIDTH'(1);
      second_count_next = second_period - PERIOD_WIDTH'(1);
    end else if (tick && running) begin
      first_count_next  = first_adv;
      second_count_next = second_adv;
      if (first_adv == first_period) begin
        first_out_next = ~first_out;
      end
      if (second_adv == second_period) begin
        second_out_next = ~second_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      first_out    <= 1'b0;
      second_out   <= 1'b0;
      first_count  <= '0;
      second_count <= '0;
    end else if (step) begin
      running      <= running_next;
      first_out    <= first_out_next;
      second_out   <= second_out_next;
      first_count  <= first_count_next;
      second_count <= second_count_next;
    end
  end

endmodule

@@ hdl/serial_command_dual_trigger_timer.sv @@
// ----------------------------------------------------------------------------
// serial_command_dual_trigger_timer
// Parses 'S' plus six digit commands and runs two toggling trigger outputs.
// ----------------------------------------------------------------------------
// path: an accepted request passes the input register, then the result register
// throughput: one request per cycle while m_axis_tready does not stall a
//   held result; parser and counters update in one pass
// reset: synchronous, clears the frame state, periods, counters and both
//   pipeline valids; the timer comes up released with both levels low
module serial_command_dual_trigger_timer
  import scdt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // byte_value
  input  logic                   s_axis_tuser,  // kind
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // first_drive, first_level, second_drive, second_level, command_done,
  // command_error, first_value[9:0], second_value[9:0], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic       in_valid;
  logic       in_kind;
  logic [7:0] in_byte;
  logic       advance;
  logic       step;
  scdt_ctl_t  ctl;
  period_t    first_period_next;
  period_t    second_period_next;
  logic       running_next;
  logic       first_out_next;
  logic       second_out_next;
  logic       out_valid;
  logic [OUT_TDATA_W-1:0] out_data;
  logic [OUT_TDATA_W-1:0] out_data_next;

  assign advance       = ~out_valid | m_axis_tready;
  assign step          = in_valid & advance;
  assign s_axis_tready = ~in_valid | advance;

  scdt_parser u_parser (
    .clk                (clk),
    .rst                (rst),
    .step               (step),
    .kind               (in_kind),
    .byte_value         (in_byte),
    .ctl                (ctl),
    .first_period_next  (first_period_next),
    .second_period_next (second_period_next)
  );

  scdt_timer u_timer (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .tick            (in_kind == KIND_TICK),
    .ctl             (ctl),
    .first_period    (first_period_next),
    .second_period   (second_period_next),
    .running_next    (running_next),
    .first_out_next  (first_out_next),
    .second_out_next (second_out_next)
  );

  always_comb begin
    out_data_next = '0;
    out_data_next[0]     = running_next;
    out_data_next[1]     = first_out_next;
    out_data_next[2]     = running_next;
    out_data_next[3]     = second_out_next;
    out_data_next[4]     = ctl.done;
    out_data_next[5]     = ctl.error;
    out_data_next[15:6]  = VALUE_WIDTH'(first_period_next);
    out_data_next[25:16] = VALUE_WIDTH'(second_period_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
    if (step) begin
      out_data <= out_data_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule
